[rtl/dcwm_pkg.sv]
`default_nettype none
package dcwm_pkg;

   // frame limits and window size
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;
   localparam int DEFAULT_MAX_RADIUS = 7;

   // pixel channel width
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int RADIUS_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] RESET_FRAME_HEIGHT = 12'd480;
   localparam logic [RADIUS_W-1:0]   RESET_RADIUS       = 3'd7;

endpackage
`default_nettype wire

[rtl/dark_channel_window_min.sv]
`default_nettype none
// flow: a pixel is taken in S_IDLE and written to the line store, the readiness
//   check runs in S_CHECK and S_CMP, and a window scan through S_SCAN and S_TAIL
//   reads one line store entry per cycle before S_EMIT hands out the result that
//   the item frees; no scan runs when the clamped window is empty
// input: a new item is taken only in S_IDLE, once the check, scan and emit for the
//   last one are through; the single read port of the line store sets the scan length
// reset: counters cleared, registers back to 640 x 480 radius 7; the line store
//   is not cleared and is only read where already written
module dark_channel_window_min #(
   parameter int MAX_WIDTH  = dcwm_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = dcwm_pkg::DEFAULT_MAX_HEIGHT,
   parameter int MAX_RADIUS = dcwm_pkg::DEFAULT_MAX_RADIUS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic                             req_is_drain,
   input  wire logic [dcwm_pkg::PIX_W-1:0]       req_blue,
   input  wire logic [dcwm_pkg::PIX_W-1:0]       req_green,
   input  wire logic [dcwm_pkg::PIX_W-1:0]       req_red,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [dcwm_pkg::PIX_W-1:0]       rsp_dark_value,
   output      logic                             rsp_frame_last,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [dcwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcwm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dcwm_pkg::*;

   localparam int SLOT_ROWS = 2 * MAX_RADIUS + 2;
   localparam int SW        = $clog2(SLOT_ROWS);
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int HW        = $clog2(MAX_HEIGHT);
   localparam int VW_RAW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_RADIUS + 2) + 1;
   localparam int VW        = (VW_RAW > CSR_DATA_W + 1) ? VW_RAW : CSR_DATA_W + 1;
   localparam int PW        = 2 * VW;
   localparam int AW        = SW + CW;
   localparam int DEPTH     = SLOT_ROWS * (2 ** CW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   // configuration registers
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [RADIUS_W-1:0]   radius_ff, radius_in;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [SW-1:0] in_slot_ff, in_slot_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [HW-1:0] out_row_ff, out_row_in;
   logic [SW-1:0] out_slot_ff, out_slot_in;
   logic          ahead_ff, ahead_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rd_valid_ff, rd_valid_in;

   // payload
   logic [PW-1:0]    have_ff, have_in;
   logic [PW-1:0]    need_ff, need_in;
   logic [HW-1:0]    row_cur_ff, row_cur_in;
   logic [HW-1:0]    rhi_ff, rhi_in;
   logic [CW-1:0]    col_cur_ff, col_cur_in;
   logic [CW-1:0]    clo_ff, clo_in;
   logic [CW-1:0]    chi_ff, chi_in;
   logic [SW-1:0]    slot_cur_ff, slot_cur_in;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   // effective frame geometry
   logic [VW-1:0] width_ext, height_ext, radius_ext;
   logic [VW-1:0] eff_w, eff_h, eff_r;
   logic [VW-1:0] orow, ocol;
   logic [VW-1:0] rlo, rhi, clo, chi, rhi_raw, chi_raw, slot_off;
   logic          win_empty;
   logic [SW-1:0] slot_start;
   logic [PIX_W-1:0] pix_min, pix_bg;

   // line store ports
   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [PIX_W-1:0] mem_rdata;

   logic req_take, out_free;

   assign width_ext  = VW'(width_ff);
   assign height_ext = VW'(height_ff);
   assign radius_ext = VW'(radius_ff);

   // clamp register values to the supported range
   always_comb begin
      eff_w = (width_ext == '0) ? VW'(1) :
              (width_ext > VW'(MAX_WIDTH)) ? VW'(MAX_WIDTH) : width_ext;
      eff_h = (height_ext == '0) ? VW'(1) :
              (height_ext > VW'(MAX_HEIGHT)) ? VW'(MAX_HEIGHT) : height_ext;
      eff_r = (radius_ext > VW'(MAX_RADIUS)) ? VW'(MAX_RADIUS) : radius_ext;
   end

   // clamped window around the next output pixel
   always_comb begin
      orow     = VW'(out_row_ff);
      ocol     = VW'(out_col_ff);
      rlo      = (orow >= eff_r) ? orow - eff_r : '0;
      clo      = (ocol >= eff_r) ? ocol - eff_r : '0;
      rhi_raw  = orow + eff_r;
      chi_raw  = ocol + eff_r;
      rhi      = (rhi_raw > eff_h - VW'(1)) ? eff_h - VW'(1) : rhi_raw;
      chi      = (chi_raw > eff_w - VW'(1)) ? eff_w - VW'(1) : chi_raw;
      win_empty = (rlo > rhi) || (clo > chi);
      slot_off = orow - rlo;
      slot_start = (out_slot_ff >= SW'(slot_off)) ? out_slot_ff - SW'(slot_off)
                 : SW'(VW'(out_slot_ff) + VW'(SLOT_ROWS) - slot_off);
   end

   // minimum over the three channels
   assign pix_bg  = (req_blue < req_green) ? req_blue : req_green;
   assign pix_min = (req_red < pix_bg) ? req_red : pix_bg;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign mem_we    = req_take && !req_is_drain;
   assign mem_waddr = {in_slot_ff, in_col_ff};
   assign mem_raddr = {slot_cur_ff, col_cur_ff};

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   width_in  = csr_data;
            CSR_FRAME_HEIGHT:  height_in = csr_data;
            CSR_WINDOW_RADIUS: radius_in = csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: write, check readiness, scan window, emit
   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_slot_in   = in_slot_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slot_in  = out_slot_ff;
      ahead_in     = ahead_ff;
      have_in      = have_ff;
      need_in      = need_ff;
      row_cur_in   = row_cur_ff;
      rhi_in       = rhi_ff;
      col_cur_in   = col_cur_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      slot_cur_in  = slot_cur_ff;
      min_in       = min_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_valid_in  = (state_ff == S_SCAN);

      // fold in the word read last cycle
      if (rd_valid_ff && (mem_rdata < min_ff)) begin
         min_in = mem_rdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CHECK;
               if (!req_is_drain) begin
                  if (VW'(in_col_ff) + VW'(1) >= eff_w) begin
                     in_col_in = '0;
                     if (VW'(in_row_ff) + VW'(1) >= eff_h) begin
                        in_row_in  = '0;
                        in_slot_in = '0;
                        ahead_in   = 1'b1;
                     end else begin
                        in_row_in  = in_row_ff + HW'(1);
                        in_slot_in = (VW'(in_slot_ff) == VW'(SLOT_ROWS - 1)) ? '0
                                   : in_slot_ff + SW'(1);
                     end
                  end else begin
                     in_col_in = in_col_ff + CW'(1);
                  end
               end
            end
         end
         S_CHECK: begin
            have_in  = PW'(in_row_ff) * PW'(eff_w) + PW'(in_col_ff);
            need_in  = PW'(rhi) * PW'(eff_w) + PW'(chi);
            state_in = S_CMP;
         end
         S_CMP: begin
            row_cur_in  = HW'(rlo);
            rhi_in      = HW'(rhi);
            col_cur_in  = CW'(clo);
            clo_in      = CW'(clo);
            chi_in      = CW'(chi);
            slot_cur_in = slot_start;
            min_in      = PIX_MAX;
            if (!ahead_ff && (have_ff <= need_ff)) begin
               state_in = S_IDLE;
            end else if (win_empty) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (col_cur_ff == chi_ff) begin
               col_cur_in = clo_ff;
               if (row_cur_ff == rhi_ff) begin
                  state_in = S_TAIL;
               end else begin
                  row_cur_in  = row_cur_ff + HW'(1);
                  slot_cur_in = (VW'(slot_cur_ff) == VW'(SLOT_ROWS - 1)) ? '0
                              : slot_cur_ff + SW'(1);
               end
            end else begin
               col_cur_in = col_cur_ff + CW'(1);
            end
         end
         S_TAIL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = min_ff;
               rsp_last_in  = 1'b0;
               if (VW'(out_col_ff) + VW'(1) >= eff_w) begin
                  out_col_in = '0;
                  if (VW'(out_row_ff) + VW'(1) >= eff_h) begin
                     out_row_in  = '0;
                     out_slot_in = '0;
                     rsp_last_in = 1'b1;
                     ahead_in    = 1'b0;
                  end else begin
                     out_row_in  = out_row_ff + HW'(1);
                     out_slot_in = (VW'(out_slot_ff) == VW'(SLOT_ROWS - 1)) ? '0
                                 : out_slot_ff + SW'(1);
                  end
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= RESET_FRAME_WIDTH;
         height_ff    <= RESET_FRAME_HEIGHT;
         radius_ff    <= RESET_RADIUS;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         ahead_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         ahead_ff     <= ahead_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      have_ff      <= have_in;
      need_ff      <= need_in;
      row_cur_ff   <= row_cur_in;
      rhi_ff       <= rhi_in;
      col_cur_ff   <= col_cur_in;
      clo_ff       <= clo_in;
      chi_ff       <= chi_in;
      slot_cur_ff  <= slot_cur_in;
      min_ff       <= min_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   dcwm_line_store #(
      .ADDR_W (AW),
      .DEPTH  (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (pix_min),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dark_value = rsp_value_ff;
   assign rsp_frame_last = rsp_last_ff;

   // read data only ever follows a scan cycle
   a_rd_after_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff) == S_SCAN)
      else $error("line store read data without a scan cycle");

   // an accepted word always goes to the readiness check
   a_take_to_check: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_CHECK)
      else $error("accepted word did not start a check");

   // a held result blocks the emit step
   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && rsp_stall) |=> state_ff == S_EMIT)
      else $error("result overwritten while held");

   // store is never written while a window scan runs
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_TAIL) |-> !mem_we)
      else $error("line store written during scan");

endmodule
`default_nettype wire

[rtl/dcwm_line_store.sv]
`default_nettype none
module dcwm_line_store #(
   parameter int ADDR_W = 15,
   parameter int DEPTH  = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [dcwm_pkg::PIX_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [dcwm_pkg::PIX_W-1:0] rd_data
);
   import dcwm_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
